FILE: sv/sbr_pkg.sv
package sbr_pkg;

  localparam int PROB_W = 17;
  localparam int GRAD_W = 32;
  // Row counter: holds the largest supported row length (64).
  localparam int CNT_W  = 7;
  // Exact product grad * prob as signed 32 x 18 bits.
  localparam int PP_W   = 50;
  // Dot accumulator, Q.32, wide enough for 64 full-scale products.
  localparam int ACC_W  = 56;
  // Dot product floored to Q24.16.
  localparam int DOT_W  = ACC_W - 16;
  localparam int DIFF_W = DOT_W + 1;
  // prob (18 bits signed) times diff.
  localparam int MUL_W  = DIFF_W + PROB_W + 1;
  localparam int FRAC_W = 16;

  // Write into the double-buffered row store.
  typedef struct packed {
    logic                     en;
    logic                     bank;
    logic [CNT_W-1:0]         idx;
    logic [PROB_W-1:0]        prob;
    logic signed [GRAD_W-1:0] grad;
  } memwr_t;

  // One finished row handed from the loader to the emitter.
  typedef struct packed {
    logic                    bank;
    logic [CNT_W-1:0]        n;
    logic signed [DOT_W-1:0] dot;
    logic                    dropped;
  } desc_t;

endpackage

FILE: sv/softmax_backward_row.sv
// Softmax backward pass for one row (Jacobian-vector product).
// Input queue: a request carries one row element, in_prob (unsigned Q1.16)
// and in_grad_in (signed Q16.16); in_row_end marks the last element. A
// request is taken when push is high and full is low.
// Result queue: while empty is low the oldest result is on out_grad_out,
// out_last_out and out_overflow; pop takes it. Each row gives one result per
// stored element, prob_j * (grad_j - dot), floored and saturated, in arrival
// order. out_overflow is set on every result of a row longer than MAX_ROW.
// A loader accepts one request per cycle while full is low, writes it into
// one of two row banks and accumulates the dot product. At row end it hands a
// row record through a two-entry queue to the emitter, which reads the bank
// one element per cycle while the result queue has room for all reads in
// flight, through a subtract and multiply pipeline (read, subtract, multiply
// registers) into an eight-entry result queue. With two banks the next row
// loads while the previous one drains; full rises only while both banks hold
// unfinished rows or while reset is held.
// When the receiver stalls, the result queue fills, the emitter pauses and
// then the loader stops once both banks are waiting.
// Reset clears all control state; the row banks need no clearing.
module softmax_backward_row import sbr_pkg::*; #(
  parameter int MAX_ROW = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  output logic                     full,
  input  logic [PROB_W-1:0]        in_prob,
  input  logic signed [GRAD_W-1:0] in_grad_in,
  input  logic                     in_row_end,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [GRAD_W-1:0] out_grad_out,
  output logic                     out_last_out,
  output logic                     out_overflow
);

  memwr_t wr;
  logic   desc_push;
  desc_t  desc;
  logic   q_empty;
  desc_t  q_desc;
  logic   q_pop;
  logic   row_done;

  // Loader: stores elements and builds the dot product.
  sbr_front #(.MAX_ROW(MAX_ROW)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (push),
    .in_prob    (in_prob),
    .in_grad_in (in_grad_in),
    .in_row_end (in_row_end),
    .full       (full),
    .row_done   (row_done),
    .wr         (wr),
    .desc_push  (desc_push),
    .desc       (desc)
  );

  // Finished rows waiting for the emitter.
  sbr_rowq u_rowq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (desc_push),
    .wdata (desc),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_desc)
  );

  // Emitter: holds the row banks and produces the results.
  sbr_back #(.MAX_ROW(MAX_ROW)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr           (wr),
    .q_empty      (q_empty),
    .q_desc       (q_desc),
    .q_pop        (q_pop),
    .row_done     (row_done),
    .empty        (empty),
    .pop          (pop),
    .out_grad_out (out_grad_out),
    .out_last_out (out_last_out),
    .out_overflow (out_overflow)
  );

endmodule

FILE: sv/sbr_front.sv
module sbr_front import sbr_pkg::*; #(
  parameter int MAX_ROW = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  input  logic [PROB_W-1:0]        in_prob,
  input  logic signed [GRAD_W-1:0] in_grad_in,
  input  logic                     in_row_end,
  output logic                     full,
  input  logic                     row_done,
  output memwr_t                   wr,
  output logic                     desc_push,
  output desc_t                    desc
);

  logic                    accept;
  logic                    has_room;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    bank_r, bank_nxt;
  logic                    drop_r, drop_nxt;
  logic [1:0]              rows_r, rows_nxt;
  logic signed [PP_W-1:0]  prod;
  logic                    s1_vld_r;
  logic signed [PP_W-1:0]  s1_prod_r;
  logic                    s1_end_r;
  logic [CNT_W-1:0]        s1_n_r;
  logic                    s1_drop_r;
  logic                    s1_bank_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ACC_W-1:0] sum;

  // Two row banks: stop taking requests while both hold unfinished rows.
  assign full     = ~rst_n | (rows_r == 2'd2);
  assign accept   = in_push & ~full;
  assign has_room = cnt_r < CNT_W'(MAX_ROW);
  assign prod     = in_grad_in * $signed({1'b0, in_prob});

  always_comb begin
    wr.en   = accept & has_room;
    wr.bank = bank_r;
    wr.idx  = cnt_r;
    wr.prob = in_prob;
    wr.grad = in_grad_in;
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    bank_nxt = bank_r;
    drop_nxt = drop_r;
    if (accept) begin
      if (in_row_end) begin
        cnt_nxt  = '0;
        bank_nxt = ~bank_r;
        drop_nxt = 1'b0;
      end else begin
        cnt_nxt  = cnt_r + CNT_W'(has_room);
        drop_nxt = drop_r | ~has_room;
      end
    end
    rows_nxt = rows_r + 2'(accept & in_row_end) - 2'(row_done);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      bank_r   <= 1'b0;
      drop_r   <= 1'b0;
      rows_r   <= '0;
      s1_vld_r <= 1'b0;
      acc_r    <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      bank_r   <= bank_nxt;
      drop_r   <= drop_nxt;
      rows_r   <= rows_nxt;
      s1_vld_r <= accept;
      acc_r    <= acc_nxt;
    end
  end

  // Product stage. A dropped element contributes nothing to the dot.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_prod_r <= has_room ? prod : '0;
      s1_end_r  <= in_row_end;
      s1_n_r    <= cnt_r + CNT_W'(has_room);
      s1_drop_r <= drop_r | ~has_room;
      s1_bank_r <= bank_r;
    end
  end

  assign sum = acc_r + ACC_W'(s1_prod_r);

  always_comb begin
    acc_nxt = acc_r;
    if (s1_vld_r) begin
      acc_nxt = s1_end_r ? '0 : sum;
    end
  end

  assign desc_push    = s1_vld_r & s1_end_r;
  assign desc.bank    = s1_bank_r;
  assign desc.n       = s1_n_r;
  assign desc.dot     = sum[ACC_W-1:FRAC_W];
  assign desc.dropped = s1_drop_r;

  a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rows_r != 2'd3)
    else $error("more rows outstanding than banks");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ROW))
    else $error("element count beyond row capacity");

  a_row_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    desc_push |-> desc.n != '0)
    else $error("finished row holds no element");

endmodule

FILE: sv/sbr_rowq.sv
module sbr_rowq import sbr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t wdata,
  input  logic  pop,
  output logic  empty,
  output desc_t rdata
);

  desc_t      ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign rdata = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= wdata;
    end
  end

endmodule

FILE: sv/sbr_back.sv
module sbr_back import sbr_pkg::*; #(
  parameter int MAX_ROW = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  memwr_t                   wr,
  input  logic                     q_empty,
  input  desc_t                    q_desc,
  output logic                     q_pop,
  output logic                     row_done,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [GRAD_W-1:0] out_grad_out,
  output logic                     out_last_out,
  output logic                     out_overflow
);

  localparam int AW       = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
  localparam int DEPTH    = 2 << AW;
  localparam int OF_DEPTH = 8;
  localparam int OF_AW    = $clog2(OF_DEPTH);
  localparam int OF_CW    = OF_AW + 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } bst_t;

  bst_t                     st_r, st_nxt;
  logic [PROB_W-1:0]        mem_p [DEPTH];
  logic signed [GRAD_W-1:0] mem_g [DEPTH];

  logic                     bank_r;
  logic [CNT_W-1:0]         n_r;
  logic signed [DOT_W-1:0]  dot_r;
  logic                     drop_r;
  logic [CNT_W-1:0]         k_r;
  logic                     issue;
  logic                     last_k;
  logic [OF_CW-1:0]         used;

  logic                     v1_r, v2_r, v3_r;
  logic [PROB_W-1:0]        p1_r, p2_r;
  logic signed [GRAD_W-1:0] g1_r;
  logic signed [DOT_W-1:0]  dot1_r;
  logic                     l1_r, l2_r, l3_r;
  logic                     d1_r, d2_r, d3_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [MUL_W-1:0]  mul_r;
  logic signed [MUL_W-FRAC_W-1:0] sh;
  logic signed [GRAD_W-1:0] res;

  logic signed [GRAD_W-1:0] of_g [OF_DEPTH];
  logic                     of_l [OF_DEPTH];
  logic                     of_d [OF_DEPTH];
  logic [OF_AW-1:0]         hd_r, tl_r;
  logic [OF_CW-1:0]         of_cnt_r;
  logic                     of_pop;

  // Reads go out only while the result queue has room for everything in flight.
  assign used   = of_cnt_r + OF_CW'(v1_r) + OF_CW'(v2_r) + OF_CW'(v3_r);
  assign last_k = (k_r == n_r - CNT_W'(1));
  assign issue  = (st_r == ST_RUN) && (used < OF_CW'(OF_DEPTH));
  assign q_pop  = (st_r == ST_IDLE) && !q_empty;
  assign row_done = issue & last_k;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (!q_empty) st_nxt = ST_RUN;
      ST_RUN:  if (issue && last_k) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      k_r      <= '0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      hd_r     <= '0;
      tl_r     <= '0;
      of_cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (q_pop) begin
        k_r <= '0;
      end else if (issue) begin
        k_r <= k_r + CNT_W'(1);
      end
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (v3_r) begin
        tl_r <= tl_r + OF_AW'(1);
      end
      if (of_pop) begin
        hd_r <= hd_r + OF_AW'(1);
      end
      of_cnt_r <= of_cnt_r + OF_CW'(v3_r) - OF_CW'(of_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      bank_r <= q_desc.bank;
      n_r    <= q_desc.n;
      dot_r  <= q_desc.dot;
      drop_r <= q_desc.dropped;
    end
  end

  // Row store, two banks of one row each.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_p[{wr.bank, wr.idx[AW-1:0]}] <= wr.prob;
      mem_g[{wr.bank, wr.idx[AW-1:0]}] <= wr.grad;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p1_r   <= mem_p[{bank_r, k_r[AW-1:0]}];
      g1_r   <= mem_g[{bank_r, k_r[AW-1:0]}];
      dot1_r <= dot_r;
      l1_r   <= last_k;
      d1_r   <= drop_r;
    end
  end

  always_ff @(posedge clk) begin
    diff_r <= DIFF_W'(g1_r) - DIFF_W'(dot1_r);
    p2_r   <= p1_r;
    l2_r   <= l1_r;
    d2_r   <= d1_r;
    mul_r  <= $signed({1'b0, p2_r}) * diff_r;
    l3_r   <= l2_r;
    d3_r   <= d2_r;
  end

  // Floor by the fraction bits, then clamp to the 32-bit signed range.
  assign sh = mul_r[MUL_W-1:FRAC_W];

  always_comb begin
    if ((&sh[MUL_W-FRAC_W-1:GRAD_W-1]) || !(|sh[MUL_W-FRAC_W-1:GRAD_W-1])) begin
      res = sh[GRAD_W-1:0];
    end else if (sh[MUL_W-FRAC_W-1]) begin
      res = {1'b1, {(GRAD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(GRAD_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (v3_r) begin
      of_g[tl_r] <= res;
      of_l[tl_r] <= l3_r;
      of_d[tl_r] <= d3_r;
    end
  end

  assign empty        = ~rst_n | (of_cnt_r == '0);
  assign of_pop       = pop & ~empty;
  assign out_grad_out = of_g[hd_r];
  assign out_last_out = of_l[hd_r];
  assign out_overflow = of_d[hd_r];

  a_of_room: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (of_cnt_r < OF_CW'(OF_DEPTH)) || of_pop)
    else $error("result queue written while full");

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RUN) |-> (k_r < n_r))
    else $error("read index past the end of the row");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    row_done |=> (st_r == ST_IDLE) && v1_r && l1_r)
    else $error("row end read not tagged as last");

endmodule

FILE: tb/softmax_backward_row_checker.sv
// Watches both queue channels of softmax_backward_row, predicts the input
// gradients of every finished row and compares them with what the block pops.
module softmax_backward_row_checker import sbr_pkg::*; #(
  parameter int MAX_ROW = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic                     full,
  input  logic [PROB_W-1:0]        in_prob,
  input  logic signed [GRAD_W-1:0] in_grad_in,
  input  logic                     in_row_end,
  input  logic                     empty,
  input  logic                     pop,
  input  logic signed [GRAD_W-1:0] out_grad_out,
  input  logic                     out_last_out,
  input  logic                     out_overflow,
  output int                       mismatch_count,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct packed {
    logic signed [GRAD_W-1:0] grad;
    logic                     last;
    logic                     ovf;
  } grad_result_t;

  // Shadow copy of the row buffer and the running dot product.
  logic [PROB_W-1:0]        row_prob [MAX_ROW];
  logic signed [GRAD_W-1:0] row_grad [MAX_ROW];
  longint                   dot_sum = 0;
  int                       n_stored = 0;
  bit                       row_dropped = 1'b0;

  grad_result_t expected_grads[$];
  int           n_bad = 0;

  assign mismatch_count = n_bad;
  assign pending        = expected_grads.size();

  // Takes one row element; on the row's last element queues one expected
  // gradient per stored element and starts a fresh row.
  function automatic void predict_row_grads(logic [PROB_W-1:0] p,
                                            logic signed [GRAD_W-1:0] g,
                                            logic row_end);
    longint       dot_q16;
    longint       prod;
    int           k;
    grad_result_t r;
    if (n_stored < MAX_ROW) begin
      row_prob[n_stored] = p;
      row_grad[n_stored] = g;
      dot_sum += longint'(g) * longint'({1'b0, p});
      n_stored++;
    end else begin
      row_dropped = 1'b1;
    end
    if (!row_end) return;
    dot_q16 = dot_sum >>> 16;
    for (k = 0; k < n_stored; k++) begin
      prod = longint'({1'b0, row_prob[k]}) * (longint'(row_grad[k]) - dot_q16);
      prod = prod >>> 16;
      if (prod > SAT_HI) prod = SAT_HI;
      else if (prod < SAT_LO) prod = SAT_LO;
      r.grad = prod[GRAD_W-1:0];
      r.last = (k == n_stored - 1);
      r.ovf  = row_dropped;
      expected_grads = {expected_grads, r};
    end
    dot_sum     = 0;
    n_stored    = 0;
    row_dropped = 1'b0;
  endfunction

  always @(posedge clk) begin
    grad_result_t want;
    if (rst_n && pop && !empty) begin
      if (expected_grads.size() == 0) begin
        $display("%0t: unexpected result, expected none, got grad_out %0d last %0b ovf %0b",
                 $time, out_grad_out, out_last_out, out_overflow);
        n_bad++;
      end else begin
        want = expected_grads.pop_front();
        if (out_grad_out !== want.grad) begin
          $display("%0t: grad_out expected %0d, got %0d", $time, want.grad, out_grad_out);
          n_bad++;
        end
        if (out_last_out !== want.last) begin
          $display("%0t: last_out expected %0b, got %0b", $time, want.last, out_last_out);
          n_bad++;
        end
        if (out_overflow !== want.ovf) begin
          $display("%0t: overflow expected %0b, got %0b", $time, want.ovf, out_overflow);
          n_bad++;
        end
      end
    end
    if (rst_n && push && !full) predict_row_grads(in_prob, in_grad_in, in_row_end);
  end

endmodule

FILE: tb/tb_softmax_backward_row.sv
// Top of the softmax backward testbench. This module only makes stimulus and
// decides the verdict; the checker beside the block predicts and compares.
module tb_softmax_backward_row import sbr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ROW      = 64;
  localparam int ITEM_TARGET  = 470;
  // The receiver goes quiet once for this long so that both row banks and
  // the result queue fill up and full is seen by the sender.
  localparam int STALL_AT     = 120;
  localparam int STALL_CYCLES = 300;
  // Cycles without any accepted request before the run is declared hung.
  // The longest legal quiet stretch is the stall above plus pipeline latency.
  localparam int HANG_LIMIT   = 2000;
  localparam logic signed [GRAD_W-1:0] GRAD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [GRAD_W-1:0] GRAD_MIN = 32'sh8000_0000;
  localparam logic [PROB_W-1:0]        PROB_ONE = 17'd65536;
  localparam logic [PROB_W-1:0]        PROB_TOP = 17'h1FFFF;

  logic                     clk;
  logic                     rst_n;
  logic                     push;
  logic                     full;
  logic [PROB_W-1:0]        in_prob;
  logic signed [GRAD_W-1:0] in_grad_in;
  logic                     in_row_end;
  logic                     empty;
  logic                     pop;
  logic signed [GRAD_W-1:0] out_grad_out;
  logic                     out_last_out;
  logic                     out_overflow;

  int mismatch_count;
  int pending;
  int stored_items = 0;
  int idle_cycles  = 0;

  softmax_backward_row #(.MAX_ROW(MAX_ROW)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_prob      (in_prob),
    .in_grad_in   (in_grad_in),
    .in_row_end   (in_row_end),
    .empty        (empty),
    .pop          (pop),
    .out_grad_out (out_grad_out),
    .out_last_out (out_last_out),
    .out_overflow (out_overflow)
  );

  softmax_backward_row_checker #(.MAX_ROW(MAX_ROW)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_prob        (in_prob),
    .in_grad_in     (in_grad_in),
    .in_row_end     (in_row_end),
    .empty          (empty),
    .pop            (pop),
    .out_grad_out   (out_grad_out),
    .out_last_out   (out_last_out),
    .out_overflow   (out_overflow),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle cycles before the next request on either side. Every fourth stretch
  // of forty requests runs back to back so that the block also sees a
  // stream with no gaps at all.
  function automatic int idle_gap(int n);
    if ((n / 40) % 4 == 3) return 0;
    return $urandom_range(0, 9);
  endfunction

  // Offers one row element and returns at the clock edge that accepted it.
  // The full flag is sampled at the falling edge, where everything has
  // settled, so the decision never depends on event order at the rising edge.
  task automatic send_elem(input logic [PROB_W-1:0] p, input logic signed [GRAD_W-1:0] g,
                           input logic row_end, input int gap);
    bit taken;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push       <= 1'b1;
    in_prob    <= p;
    in_grad_in <= g;
    in_row_end <= row_end;
    do begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end while (!taken);
  endtask

  // Probabilities mostly stay in [0, 1], with exact zero, exact one and the
  // patterns above one mixed in; the full 17-bit draw toggles every bit.
  function automatic logic [PROB_W-1:0] pick_prob();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return PROB_ONE;
      2:       return PROB_W'($urandom);
      3:       return PROB_W'($urandom_range(65537, 131071));
      default: return PROB_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic signed [GRAD_W-1:0] pick_grad();
    case ($urandom_range(0, 9))
      0:       return GRAD_MAX;
      1:       return GRAD_MIN;
      2, 3, 4: return GRAD_W'($urandom);
      default: return GRAD_W'(int'($urandom_range(0, 1048576)) - 524288);
    endcase
  endfunction

  // Sends a row of random elements. Elements past MAX_ROW are dropped by the
  // block, so they do not count toward the item total.
  task automatic send_row(input int len);
    int k;
    for (k = 0; k < len; k++) begin
      send_elem(pick_prob(), pick_grad(), k == len - 1, idle_gap(stored_items));
      if (k < MAX_ROW) stored_items++;
    end
  endtask

  // Sender: reset, a short directed part, then random rows.
  initial begin
    int row_idx;
    int len;
    rst_n      = 1'b0;
    push       = 1'b0;
    in_prob    = '0;
    in_grad_in = '0;
    in_row_end = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-element rows: zero probability, and exact one where the result
    // must cancel to zero, at both gradient extremes.
    send_elem('0, GRAD_MAX, 1'b1, 0);
    send_elem(PROB_ONE, GRAD_MIN, 1'b1, 0);
    send_elem(PROB_ONE, GRAD_MAX, 1'b1, 0);
    // Probabilities above one with extreme gradients drive both ends of the
    // result into saturation.
    send_elem(PROB_TOP, GRAD_MIN, 1'b0, 0);
    send_elem(PROB_TOP, GRAD_MAX, 1'b1, 0);
    send_elem(PROB_TOP, GRAD_MAX, 1'b0, 1);
    send_elem(PROB_TOP, GRAD_MIN, 1'b1, 0);
    // Alternating bit patterns and smallest nonzero values.
    send_elem(17'h0AAAA, 32'shAAAA_AAAA, 1'b0, 2);
    send_elem(17'h15555, 32'sh5555_5555, 1'b0, 0);
    send_elem(17'd1, -32'sd1, 1'b0, 0);
    send_elem(PROB_ONE, 32'sd1, 1'b1, 3);
    // A row of all-zero probabilities and a uniform split of one.
    send_elem('0, 32'sd65536, 1'b0, 0);
    send_elem('0, -32'sd65536, 1'b1, 0);
    send_elem(17'd16384, 32'sd65536, 1'b0, 0);
    send_elem(17'd16384, 32'sd131072, 1'b0, 0);
    send_elem(17'd16384, -32'sd65536, 1'b0, 0);
    send_elem(17'd16384, '0, 1'b1, 0);
    stored_items = 17;

    // Random rows. A few fixed lengths make sure a row fills the buffer
    // exactly, a row ends on a dropped element, and a row ends on a dropped
    // element after earlier drops; otherwise most rows are short.
    row_idx = 0;
    while (stored_items < ITEM_TARGET) begin
      case (row_idx)
        3:       len = MAX_ROW;
        7:       len = MAX_ROW + 1;
        11:      len = MAX_ROW + 4;
        default: begin
          case ($urandom_range(0, 49))
            0, 1:          len = $urandom_range(MAX_ROW - 4, MAX_ROW + 6);
            2, 3, 4, 5, 6,
            7, 8, 9:       len = $urandom_range(9, 30);
            default:       len = $urandom_range(1, 8);
          endcase
        end
      endcase
      send_row(len);
      row_idx++;
    end
    push <= 1'b0;

    // Every request is in; wait for the results still owed, then give the
    // pipeline time to show any result that should not exist. The first wait
    // lets the checker take the last request before its count is read.
    do @(negedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Receiver: random pauses between pops, plus one long hold-off that lets
  // the block back up all the way to its input.
  initial begin
    int  n_popped;
    int  gap;
    bit  taken;
    pop      = 1'b0;
    n_popped = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = (n_popped == STALL_AT) ? STALL_CYCLES : idle_gap(n_popped + 20);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do begin
        @(negedge clk);
        taken = !empty;
        @(posedge clk);
      end while (!taken);
      n_popped++;
    end
  end

  // Hang detection: any accepted request on either channel restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == HANG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule
